>>> hw/rtl/clcd_pkg.sv
// Shared types, constants and helper functions for the character LCD cursor controller.
// No dependencies; every other file of the block imports this package.
package clcd_pkg;

    // Display geometry.
    localparam int COLS       = 16;
    localparam int ROWS       = 2;
    localparam int CELL_COUNT = COLS * ROWS;
    localparam int IDX_W      = 7;
    localparam int MAX_RES    = 4;
    localparam int CNT_W      = 3;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx C_COLS        = IDX_W'(COLS);
    localparam t_idx LAST_IDX      = IDX_W'(CELL_COUNT - 1);
    localparam t_idx LAST_ROW_BASE = IDX_W'((ROWS - 1) * COLS);
    localparam logic LAST_ROW      = 1'(ROWS - 1);

    typedef enum logic [1:0] {
        CMD_WRITE_CHAR = 2'd0,
        CMD_MOVE       = 2'd1,
        CMD_SET_POS    = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MV_RIGHT     = 3'd0,
        MV_LEFT      = 3'd1,
        MV_UP        = 3'd2,
        MV_DOWN      = 3'd3,
        MV_ROW_END   = 3'd4,
        MV_ROW_START = 3'd5,
        MV_TOP       = 3'd6,
        MV_BOTTOM    = 3'd7
    } t_move;

    // Register-select codes on the LCD bus.
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // Bus bytes and character codes.
    localparam logic [7:0] BYTE_CLEAR    = 8'h01;
    localparam logic [7:0] BYTE_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] BYTE_UNKNOWN  = 8'hA5;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_RETURN     = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] MAX_PRINT_RST = 8'd127;

    // Everything one command produces: the bus writes and the next cursor state.
    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic [MAX_RES-1:0]      rs;
        logic [MAX_RES-1:0][7:0] data;
        t_idx                    idx;
        logic                    pend;
    } t_plan;

    // Row of a linear index; the display has at most two rows.
    function automatic logic row_of(input t_idx idx);
        row_of = (ROWS > 1) && (idx >= C_COLS);
    endfunction

    function automatic t_idx col_of(input t_idx idx);
        col_of = row_of(idx) ? (idx - C_COLS) : idx;
    endfunction

    // Set-DDRAM-address command for a linear index.
    function automatic logic [7:0] pos_byte(input t_idx idx);
        logic [7:0] offs;
        offs     = row_of(idx) ? ROW1_OFFSET : 8'h00;
        pos_byte = BYTE_SET_ADDR | (offs + 8'(col_of(idx)));
    endfunction

    // Folds Latin-1 accented vowels and C-cedilla to plain ASCII; anything else maps to the block glyph.
    function automatic logic [7:0] fold_code(input logic [7:0] c);
        if (c >= 8'hC0 && c <= 8'hC4)      fold_code = "A";
        else if (c == 8'hC7)               fold_code = "C";
        else if (c >= 8'hC8 && c <= 8'hCB) fold_code = "E";
        else if (c >= 8'hCC && c <= 8'hCF) fold_code = "I";
        else if (c >= 8'hD2 && c <= 8'hD6) fold_code = "O";
        else if (c >= 8'hD9 && c <= 8'hDC) fold_code = "U";
        else if (c >= 8'hE0 && c <= 8'hE4) fold_code = "a";
        else if (c == 8'hE7)               fold_code = "c";
        else if (c >= 8'hE8 && c <= 8'hEB) fold_code = "e";
        else if (c >= 8'hEC && c <= 8'hEF) fold_code = "i";
        else if (c >= 8'hF2 && c <= 8'hF6) fold_code = "o";
        else if (c >= 8'hF9 && c <= 8'hFC) fold_code = "u";
        else                               fold_code = BYTE_UNKNOWN;
    endfunction

endpackage

>>> hw/rtl/clcd_decode.sv
// Command decoder: turns one command and the cursor state into a list of bus writes and the next cursor state.
// Depends on clcd_pkg.
module clcd_decode import clcd_pkg::*; (
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char,
    input  logic [2:0] i_move,
    input  logic [5:0] i_col,
    input  logic [1:0] i_row,
    input  logic [7:0] i_max_printable,
    input  t_idx       i_idx,
    input  logic       i_pend,
    output t_plan      o_plan
);

    logic             cur_row;
    t_idx             cur_col;
    t_idx             row_base;
    t_idx             fwd_idx;
    t_idx             mv_idx;
    logic             mv_wrap;
    logic [2:0]       mv_kind;
    logic             do_move;
    logic             sp_ok;
    t_idx             sp_idx;
    logic [7:0]       printed;
    logic [CNT_W-1:0] k;
    t_plan            plan;

    assign cur_row  = row_of(i_idx);
    assign cur_col  = col_of(i_idx);
    assign row_base = cur_row ? C_COLS : '0;
    assign fwd_idx  = (i_idx >= LAST_IDX) ? '0 : (i_idx + 1'b1);
    assign printed  = (i_char <= i_max_printable) ? i_char : fold_code(i_char);
    assign sp_ok    = ({1'b0, i_col} < C_COLS) && ({1'b0, i_row} < 3'(ROWS));
    assign sp_idx   = IDX_W'(i_col) + (i_row[0] ? C_COLS : '0);

    // Newline and carriage return reuse the move-down and row-start paths.
    always_comb begin
        do_move = 1'b0;
        mv_kind = i_move;
        case (t_cmd'(i_cmd))
            CMD_MOVE: begin
                do_move = 1'b1;
            end
            CMD_WRITE_CHAR: begin
                if (i_char == CH_NEWLINE) begin
                    do_move = 1'b1;
                    mv_kind = MV_DOWN;
                end else if (i_char == CH_RETURN) begin
                    do_move = 1'b1;
                    mv_kind = MV_ROW_START;
                end
            end
            default: begin
                do_move = 1'b0;
            end
        endcase
    end

    always_comb begin
        mv_idx  = i_idx;
        mv_wrap = 1'b0;
        case (t_move'(mv_kind))
            MV_RIGHT: mv_idx = fwd_idx;
            MV_LEFT:  mv_idx = (i_idx == '0) ? LAST_IDX : (i_idx - 1'b1);
            MV_UP: begin
                if (!cur_row) begin
                    mv_idx  = LAST_ROW_BASE + cur_col;
                    mv_wrap = 1'b1;
                end else begin
                    mv_idx = i_idx - C_COLS;
                end
            end
            MV_DOWN: begin
                if (cur_row == LAST_ROW) begin
                    mv_idx  = cur_col;
                    mv_wrap = 1'b1;
                end else begin
                    mv_idx = i_idx + C_COLS;
                end
            end
            MV_ROW_END:   mv_idx = row_base + C_COLS - 1'b1;
            MV_ROW_START: mv_idx = row_base;
            MV_TOP:       mv_idx = cur_col;
            default:      mv_idx = LAST_ROW_BASE + cur_col;
        endcase
    end

    // Writes are appended in order; k is the next free slot.
    always_comb begin
        plan      = '0;
        plan.idx  = i_idx;
        plan.pend = i_pend;
        k         = '0;
        if (do_move) begin
            plan.idx        = mv_idx;
            plan.pend       = i_pend | mv_wrap;
            plan.rs[k[1:0]]   = RS_CMD;
            plan.data[k[1:0]] = pos_byte(mv_idx);
            k               = k + 1'b1;
        end else begin
            case (t_cmd'(i_cmd))
                CMD_WRITE_CHAR: begin
                    if (i_char >= CH_SPACE) begin
                        if (i_pend) begin
                            plan.rs[k[1:0]]   = RS_CMD;
                            plan.data[k[1:0]] = BYTE_CLEAR;
                            k                 = k + 1'b1;
                            plan.rs[k[1:0]]   = RS_CMD;
                            plan.data[k[1:0]] = pos_byte(i_idx);
                            k                 = k + 1'b1;
                            plan.pend         = 1'b0;
                        end
                        plan.rs[k[1:0]]   = RS_DATA;
                        plan.data[k[1:0]] = printed;
                        k                 = k + 1'b1;
                        plan.idx          = fwd_idx;
                        if (row_of(fwd_idx) != cur_row) begin
                            plan.rs[k[1:0]]   = RS_CMD;
                            plan.data[k[1:0]] = pos_byte(fwd_idx);
                            k                 = k + 1'b1;
                        end
                    end
                end
                CMD_SET_POS: begin
                    if (sp_ok) begin
                        plan.idx          = sp_idx;
                        plan.rs[k[1:0]]   = RS_CMD;
                        plan.data[k[1:0]] = pos_byte(sp_idx);
                        k                 = k + 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    plan.idx          = '0;
                    plan.rs[k[1:0]]   = RS_CMD;
                    plan.data[k[1:0]] = BYTE_CLEAR;
                    k                 = k + 1'b1;
                end
                default: begin
                    plan.idx = i_idx;
                end
            endcase
        end
        plan.cnt = k;
        o_plan   = plan;
    end

endmodule

>>> hw/rtl/char_lcd_cursor_controller.sv
// Character LCD cursor controller: command stream in, HD44780 bus writes out.
// Depends on clcd_pkg and clcd_decode.
// A command is held in the input register and decoded from it; once the result queue is free, its
// 0 to 4 bus writes load there and leave as the output port takes them; the next command can be taken then.
// Reset (synchronous, active low): cursor at index 0, no clear pending, max_printable 127, queues empty.
module char_lcd_cursor_controller import clcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // char_code[7:0], move_kind[10:8], col[16:11], row[18:17]
    input  logic [1:0]  i_s_axis_tuser,  // command[1:0]
    // LCD bus write stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // bus_byte[7:0]
    output logic        o_m_axis_tuser,  // register_select[0]
    output logic        o_m_axis_tlast,
    // Configuration write channel for max_printable.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    // The input register holds one command until the result queue can take its writes.
    logic                    r_in_valid;
    logic [1:0]              r_cmd;
    logic [7:0]              r_char;
    logic [2:0]              r_move;
    logic [5:0]              r_col;
    logic [1:0]              r_row;

    // Cursor state and the configuration register.
    t_idx                    r_idx;
    logic                    r_pend;
    logic [7:0]              r_max_printable;

    // Result queue: up to four bus writes of one command, entry 0 is at the output.
    logic [CNT_W-1:0]        r_cnt;
    logic [MAX_RES-1:0]      r_rs;
    logic [MAX_RES-1:0][7:0] r_data;

    t_plan                   plan;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    queue_free;
    logic                    advance;

    clcd_decode u_decode (
        .i_cmd           (r_cmd),
        .i_char          (r_char),
        .i_move          (r_move),
        .i_col           (r_col),
        .i_row           (r_row),
        .i_max_printable (r_max_printable),
        .i_idx           (r_idx),
        .i_pend          (r_pend),
        .o_plan          (plan)
    );

    // The queue may be reloaded when it is empty or its final write leaves in this cycle,
    // so a one-write command every cycle streams without gaps while the output port is ready.
    assign out_xfer   = o_m_axis_tvalid && i_m_axis_tready;
    assign queue_free = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_m_axis_tready);
    assign advance    = r_in_valid && queue_free;
    assign in_xfer    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = i_rst_n && (!r_in_valid || advance);
    assign o_cfg_ready     = i_rst_n;

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_data[0];
    assign o_m_axis_tuser  = r_rs[0];
    assign o_m_axis_tlast  = (r_cnt == CNT_W'(1));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_idx           <= '0;
            r_pend          <= 1'b0;
            r_max_printable <= MAX_PRINT_RST;
            r_cnt           <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_printable <= i_cfg_data;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_idx  <= plan.idx;
                r_pend <= plan.pend;
                r_cnt  <= plan.cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char <= i_s_axis_tdata[7:0];
            r_move <= i_s_axis_tdata[10:8];
            r_col  <= i_s_axis_tdata[16:11];
            r_row  <= i_s_axis_tdata[18:17];
            r_cmd  <= i_s_axis_tuser;
        end
        if (advance) begin
            r_rs   <= plan.rs;
            r_data <= plan.data;
        end else if (out_xfer) begin
            r_rs   <= {1'b0, r_rs[MAX_RES-1:1]};
            r_data <= {8'h00, r_data[MAX_RES-1:1]};
        end
    end

endmodule

>>> hw/rtl/clcd_checker.sv
// Port-level checks for the character LCD cursor controller, bound to the top level.
// Depends on clcd_pkg and char_lcd_cursor_controller.
module clcd_checker import clcd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // A stalled write holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled bus write changed");

    // A write that is not the last of its command is followed at once by the next one.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside the writes of one command");

    // Command writes are either a clear or a set-address.
    a_cmd_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == RS_CMD) |->
            (o_m_axis_tdata == BYTE_CLEAR) || o_m_axis_tdata[7])
        else $error("unexpected command byte");

    // A clear that opens a printed character is followed by the cursor address.
    a_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
        && (o_m_axis_tuser == RS_CMD) && (o_m_axis_tdata == BYTE_CLEAR) |=>
            (o_m_axis_tuser == RS_CMD) && o_m_axis_tdata[7])
        else $error("clear not followed by cursor address");

endmodule

bind char_lcd_cursor_controller clcd_checker u_clcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> tb/tb_char_lcd_cursor_controller.sv
// Self-checking testbench for the character LCD cursor controller: commands in, bus writes out.
// Depends on clcd_pkg and the RTL of char_lcd_cursor_controller; it reads no files.
module tb_char_lcd_cursor_controller import clcd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle cycles allowed after the last result before a register write or the end of the
    // run. A command with no bus write gives no sign of finishing, so this covers its decode.
    localparam int SETTLE_CYCLES  = 8;
    // Cycles in a row without any transfer on any channel before the run is called hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // What the command driver works through: a command, a pause until the block has
    // drained, or a write of max_printable.
    typedef enum logic [1:0] {
        STEP_CMD,
        STEP_SETTLE,
        STEP_CFG
    } t_step;

    typedef struct {
        t_step      op;
        t_cmd       cmd;
        logic [7:0] ch;
        logic [2:0] kind;
        logic [5:0] col;
        logic [1:0] row;
        logic [7:0] cfg;
    } t_lcd_step;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_bus_write;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        s_tvalid         = 1'b0;
    logic [23:0] s_tdata          = '0;
    logic [1:0]  s_tuser          = '0;
    logic        m_tready         = 1'b0;
    logic        cfg_valid        = 1'b0;
    logic [7:0]  cfg_data         = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_cfg_ready;

    // Pending stimulus and the bus writes the predictor expects, oldest first.
    t_lcd_step  lcd_steps_q[$];
    t_bus_write exp_bus_writes[$];

    // Predictor copy of the block state and its register.
    t_idx       cur_idx    = '0;
    logic       clr_pend   = 1'b0;
    logic [7:0] max_print  = MAX_PRINT_RST;

    // Driver bookkeeping.
    t_lcd_step  cmd_on_bus;
    int         burst_left  = 1;
    int         gap_left    = 0;
    int         settle_left = SETTLE_CYCLES;
    logic       stim_done   = 1'b0;

    // Monitor bookkeeping.
    logic [15:0] ready_pat   = 16'hFFFF;
    int          pat_age     = 0;
    int          idle_cycles = 0;
    int          fail_count  = 0;

    char_lcd_cursor_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Reset is held at the start of the run and never asserted again.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Set-DDRAM-address byte for a linear cursor index: row 1 starts at offset 0x40.
    function automatic logic [7:0] ddram_addr(input t_idx idx);
        int r;
        int c;
        r = idx / COLS;
        c = idx % COLS;
        return BYTE_SET_ADDR | ((r == 1 ? ROW1_OFFSET : 8'h00) + 8'(c));
    endfunction

    // Works out the bus writes of one accepted command and updates the predicted state.
    function automatic void predict_bus_writes(input t_lcd_step it);
        t_bus_write wr[$];
        int         r;
        int         c;
        logic       move_now;
        t_move      mv;
        logic [7:0] glyph;
        logic [7:0] letter;
        logic [7:0] upper;
        r        = cur_idx / COLS;
        c        = cur_idx % COLS;
        move_now = 1'b0;
        mv       = t_move'(it.kind);
        case (it.cmd)
            CMD_WRITE_CHAR: begin
                if (it.ch < CH_SPACE) begin
                    // Newline and carriage return act as moves; other control codes do nothing.
                    if (it.ch == CH_NEWLINE) begin
                        move_now = 1'b1;
                        mv       = MV_DOWN;
                    end else if (it.ch == CH_RETURN) begin
                        move_now = 1'b1;
                        mv       = MV_ROW_START;
                    end
                end else begin
                    // A pending clear goes out ahead of the character, followed by the
                    // unchanged cursor address.
                    if (clr_pend) begin
                        wr.push_back(t_bus_write'{RS_CMD, BYTE_CLEAR, 1'b0});
                        wr.push_back(t_bus_write'{RS_CMD, ddram_addr(cur_idx), 1'b0});
                        clr_pend = 1'b0;
                    end
                    glyph = it.ch;
                    if (it.ch > max_print) begin
                        // Upper and lower case accented letters differ only in bit 5, so
                        // fold on the upper case form and put the case back afterward.
                        letter = 8'h00;
                        upper  = it.ch & 8'hDF;
                        if (it.ch >= 8'hC0) begin
                            if (upper <= 8'hC4) letter = "A";
                            else if (upper == 8'hC7) letter = "C";
                            else if (upper >= 8'hC8 && upper <= 8'hCB) letter = "E";
                            else if (upper >= 8'hCC && upper <= 8'hCF) letter = "I";
                            else if (upper >= 8'hD2 && upper <= 8'hD6) letter = "O";
                            else if (upper >= 8'hD9 && upper <= 8'hDC) letter = "U";
                        end
                        glyph = (letter == 8'h00) ? BYTE_UNKNOWN : (letter | (it.ch & 8'h20));
                    end
                    wr.push_back(t_bus_write'{RS_DATA, glyph, 1'b0});
                    cur_idx = (cur_idx == LAST_IDX) ? t_idx'(0) : cur_idx + 1'b1;
                    if (cur_idx / COLS != r) begin
                        wr.push_back(t_bus_write'{RS_CMD, ddram_addr(cur_idx), 1'b0});
                    end
                end
            end
            CMD_MOVE: begin
                move_now = 1'b1;
            end
            CMD_SET_POS: begin
                if (it.col < COLS && it.row < ROWS) begin
                    cur_idx = t_idx'(it.row * COLS + it.col);
                    wr.push_back(t_bus_write'{RS_CMD, ddram_addr(cur_idx), 1'b0});
                end
            end
            default: begin
                wr.push_back(t_bus_write'{RS_CMD, BYTE_CLEAR, 1'b0});
                cur_idx = '0;
            end
        endcase
        if (move_now) begin
            case (mv)
                MV_RIGHT:     cur_idx = (cur_idx == LAST_IDX) ? t_idx'(0) : cur_idx + 1'b1;
                MV_LEFT:      cur_idx = (cur_idx == 0) ? LAST_IDX : cur_idx - 1'b1;
                MV_UP: begin
                    // Wrapping off the top lands on the last row and marks a clear pending.
                    if (r == 0) begin
                        cur_idx  = t_idx'((ROWS - 1) * COLS + c);
                        clr_pend = 1'b1;
                    end else begin
                        cur_idx = cur_idx - C_COLS;
                    end
                end
                MV_DOWN: begin
                    if (r >= ROWS - 1) begin
                        cur_idx  = t_idx'(c);
                        clr_pend = 1'b1;
                    end else begin
                        cur_idx = cur_idx + C_COLS;
                    end
                end
                MV_ROW_END:   cur_idx = t_idx'((r + 1) * COLS - 1);
                MV_ROW_START: cur_idx = t_idx'(r * COLS);
                MV_TOP:       cur_idx = t_idx'(c);
                default:      cur_idx = t_idx'((ROWS - 1) * COLS + c);
            endcase
            wr.push_back(t_bus_write'{RS_CMD, ddram_addr(cur_idx), 1'b0});
        end
        if (wr.size() > 0) begin
            wr[wr.size() - 1].last = 1'b1;
        end
        foreach (wr[k]) begin
            exp_bus_writes.push_back(wr[k]);
        end
    endfunction

    task automatic add_cmd(input t_cmd cmd, input logic [7:0] ch, input logic [2:0] kind,
                           input logic [5:0] col, input logic [1:0] row);
        t_lcd_step it;
        it = '{STEP_CMD, cmd, ch, kind, col, row, 8'h00};
        lcd_steps_q.push_back(it);
    endtask

    // The register is only written once the block has gone quiet.
    task automatic add_cfg(input logic [7:0] value);
        t_lcd_step it;
        it = '{STEP_SETTLE, CMD_CLEAR, 8'h00, 3'd0, 6'd0, 2'd0, 8'h00};
        lcd_steps_q.push_back(it);
        it.op  = STEP_CFG;
        it.cfg = value;
        lcd_steps_q.push_back(it);
    endtask

    // Random commands weighted toward printing, so the cursor keeps crossing rows and
    // wrapping, with moves often enough to raise the pending clear.
    task automatic add_random(input int n);
        t_lcd_step it;
        int        sel;
        int        pick;
        for (int i = 0; i < n; i++) begin
            it.op   = STEP_CMD;
            it.cfg  = 8'h00;
            it.ch   = 8'($urandom);
            it.kind = 3'($urandom);
            it.col  = 6'($urandom);
            it.row  = 2'($urandom);
            sel     = $urandom_range(0, 99);
            if (sel < 55) begin
                it.cmd = CMD_WRITE_CHAR;
                pick   = $urandom_range(0, 19);
                if (pick < 12) it.ch = 8'($urandom_range(32, 126));
                else if (pick < 17) it.ch = 8'($urandom_range(127, 255));
                else if (pick == 17) it.ch = CH_NEWLINE;
                else if (pick == 18) it.ch = CH_RETURN;
                else it.ch = 8'($urandom_range(0, 31));
            end else if (sel < 80) begin
                it.cmd = CMD_MOVE;
            end else if (sel < 93) begin
                it.cmd = CMD_SET_POS;
                if ($urandom_range(0, 3) != 0) begin
                    it.col = 6'($urandom_range(0, COLS - 1));
                    it.row = 2'($urandom_range(0, ROWS - 1));
                end
            end else begin
                it.cmd = CMD_CLEAR;
            end
            lcd_steps_q.push_back(it);
        end
    endtask

    // Command driver. A transfer is predicted at the edge where it happens; the next step is
    // only taken once neither channel has an offer waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                predict_bus_writes(cmd_on_bus);
            end
            if (cfg_valid && o_cfg_ready) begin
                max_print = cfg_data;
            end
            if ((s_tvalid && !o_s_axis_tready) || (cfg_valid && !o_cfg_ready)) begin
                // Offer still open; hold everything.
            end else if (lcd_steps_q.size() == 0) begin
                s_tvalid  <= 1'b0;
                cfg_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (lcd_steps_q[0].op == STEP_SETTLE) begin
                // Wait until every expected write has come out and the settle count has run down.
                s_tvalid  <= 1'b0;
                cfg_valid <= 1'b0;
                if (exp_bus_writes.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left > 0) begin
                    settle_left--;
                end else begin
                    settle_left = SETTLE_CYCLES;
                    void'(lcd_steps_q.pop_front());
                end
            end else if (gap_left > 0) begin
                s_tvalid  <= 1'b0;
                cfg_valid <= 1'b0;
                gap_left--;
            end else if (lcd_steps_q[0].op == STEP_CFG) begin
                s_tvalid  <= 1'b0;
                cfg_valid <= 1'b1;
                cfg_data  <= lcd_steps_q[0].cfg;
                void'(lcd_steps_q.pop_front());
            end else begin
                cmd_on_bus = lcd_steps_q.pop_front();
                s_tvalid  <= 1'b1;
                cfg_valid <= 1'b0;
                s_tuser   <= cmd_on_bus.cmd;
                s_tdata   <= {5'b0, cmd_on_bus.row, cmd_on_bus.col, cmd_on_bus.kind,
                              cmd_on_bus.ch};
                // Bursts of random length; about a quarter of them run on with no gap.
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Bus write monitor and receiver. Ready follows a rotating 16-bit pattern that is
    // reloaded each time pat_age wraps, sometimes with all ones for a stall-free stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready    <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (exp_bus_writes.size() == 0) begin
                    $error("bus write with nothing expected: rs %0d byte %02h last %0d",
                           o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                    fail_count++;
                end else begin
                    t_bus_write exp_wr;
                    exp_wr = exp_bus_writes.pop_front();
                    if (o_m_axis_tuser !== exp_wr.rs) begin
                        $error("register_select: expected %0d, got %0d",
                               exp_wr.rs, o_m_axis_tuser);
                        fail_count++;
                    end
                    if (o_m_axis_tdata !== exp_wr.data) begin
                        $error("bus_byte: expected %02h, got %02h", exp_wr.data, o_m_axis_tdata);
                        fail_count++;
                    end
                    if (o_m_axis_tlast !== exp_wr.last) begin
                        $error("last: expected %0d, got %0d", exp_wr.last, o_m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if ((o_m_axis_tvalid && m_tready) || (s_tvalid && o_s_axis_tready)
                    || (cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            pat_age++;
            if (pat_age == 64) begin
                pat_age   = 0;
                ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            end
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            m_tready <= ready_pat[0];
        end
    end

    initial begin
        // Directed commands at the reset value of max_printable (127), cursor at 0.
        add_cmd(CMD_WRITE_CHAR, CH_SPACE, 3'd0, 6'd0, 2'd0);     // lowest printable
        add_cmd(CMD_WRITE_CHAR, 8'h7E, 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_WRITE_CHAR, 8'h7F, 3'd0, 6'd0, 2'd0);        // equal to the limit
        add_cmd(CMD_WRITE_CHAR, 8'h80, 3'd0, 6'd0, 2'd0);        // unknown high code
        add_cmd(CMD_WRITE_CHAR, 8'hC0, 3'd0, 6'd0, 2'd0);        // folds to a capital
        add_cmd(CMD_WRITE_CHAR, 8'hFC, 3'd0, 6'd0, 2'd0);        // folds to a small letter
        add_cmd(CMD_WRITE_CHAR, 8'hFF, 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_WRITE_CHAR, 8'h00, 3'd7, 6'd63, 2'd3);       // control codes: no write
        add_cmd(CMD_WRITE_CHAR, 8'h1F, 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_WRITE_CHAR, CH_NEWLINE, 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_WRITE_CHAR, CH_RETURN, 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_LEFT, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_RIGHT, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_ROW_END, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_RIGHT, 6'd0, 2'd0);          // wraps from the last cell
        add_cmd(CMD_MOVE, 8'h00, MV_LEFT, 6'd0, 2'd0);           // wraps back
        add_cmd(CMD_MOVE, 8'h00, MV_UP, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_UP, 6'd0, 2'd0);             // off the top: clear pending
        add_cmd(CMD_SET_POS, 8'h00, 3'd0, 6'd15, 2'd0);
        // Pending clear plus a row change: clear, address, data, address.
        add_cmd(CMD_WRITE_CHAR, "Z", 3'd0, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_BOTTOM, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_TOP, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_DOWN, 6'd0, 2'd0);
        add_cmd(CMD_MOVE, 8'h00, MV_DOWN, 6'd0, 2'd0);           // off the bottom
        add_cmd(CMD_SET_POS, 8'h00, 3'd0, 6'd16, 2'd0);          // column out of range
        add_cmd(CMD_SET_POS, 8'h00, 3'd0, 6'd0, 2'd2);           // row out of range
        add_cmd(CMD_SET_POS, 8'hFF, 3'd7, 6'd63, 2'd3);
        add_cmd(CMD_CLEAR, 8'h00, 3'd0, 6'd0, 2'd0);             // keeps the pending clear
        add_cmd(CMD_WRITE_CHAR, "a", 3'd0, 6'd0, 2'd0);
        // Random phases over several register settings, the extremes among them.
        add_cfg(8'd255);
        add_random(60);
        add_cfg(8'd32);
        add_random(30);
        add_cfg(8'd32);      // rewrite after a full drain, as a pause under load
        add_random(30);
        add_cfg(8'($urandom_range(33, 254)));
        add_random(60);
        add_cfg(8'($urandom_range(33, 254)));
        add_random(60);
        add_cfg(MAX_PRINT_RST);
        add_random(60);

        while (!(stim_done && exp_bus_writes.size() == 0) && idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
        end else begin
            // Leave room for any stray write that would come after the last expected one.
            repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
            if (fail_count == 0 && exp_bus_writes.size() == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule
